@@ rtl/clcd_pkg.sv @@
// Package of types, codes and the power-up table for the character display sequencer.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  // Widths of the request and operation fields.
  localparam int unsigned ReqW    = 3;
  localparam int unsigned ValW    = 8;
  localparam int unsigned ColW    = 6;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned KindW   = 2;
  localparam int unsigned NibW    = 4;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;

  // Default number of characters blanked by a clear-line request.
  localparam int unsigned LineCharsDefault = 16;

  // The power-up sequence is a fixed list of operations.
  localparam int unsigned InitOps  = 25;
  localparam int unsigned InitIdxW = 5;

  // Request codes.
  localparam logic [ReqW-1:0] ReqInit    = 3'd0;
  localparam logic [ReqW-1:0] ReqCmd     = 3'd1;
  localparam logic [ReqW-1:0] ReqChar    = 3'd2;
  localparam logic [ReqW-1:0] ReqPos     = 3'd3;
  localparam logic [ReqW-1:0] ReqPosClr  = 3'd4;

  // Operation kinds.
  localparam logic [KindW-1:0] OpPoll = 2'd0;
  localparam logic [KindW-1:0] OpNib  = 2'd1;
  localparam logic [KindW-1:0] OpWait = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBusyPollLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSecondRowBase = 1'b1;

  // Display constants.
  localparam logic [AddrW-1:0] SecondRowBaseReset = 7'h40;
  localparam logic [ValW-1:0]  SpaceChar          = 8'h20;

  // Byte phases: busy poll, high nibble, low nibble.
  localparam logic [1:0] PhPoll = 2'd0;
  localparam logic [1:0] PhHigh = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StCmd,
    StPosA,
    StSpace,
    StPosB
  } state_e;

  // Where the byte of a three-operation transfer comes from.
  typedef enum logic [1:0] {
    SrcInit,
    SrcVal,
    SrcPos,
    SrcSpace
  } src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                emit;
    src_e                src;
    logic [1:0]          phase;
    logic [InitIdxW-1:0] init_idx;
    logic                rs;
    logic                last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [NibW-1:0]  nib;
    logic [WaitW-1:0] wait_us;
  } init_op_t;

  // Power-up sequence: nibble resets with their waits, then function set,
  // display off, clear, a wait, entry mode and display on.
  function automatic init_op_t init_op(input logic [InitIdxW-1:0] idx);
    init_op_t op;
    op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
    case (idx)
      5'd0:  op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd50000};
      5'd1:  op = '{kind: OpNib,  nib: 4'h3, wait_us: 16'd0};
      5'd2:  op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd5000};
      5'd3:  op = '{kind: OpNib,  nib: 4'h3, wait_us: 16'd0};
      5'd4:  op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd150};
      5'd5:  op = '{kind: OpNib,  nib: 4'h3, wait_us: 16'd0};
      5'd6:  op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd150};
      5'd7:  op = '{kind: OpNib,  nib: 4'h2, wait_us: 16'd0};
      5'd8:  op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd150};
      5'd9:  op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
      5'd10: op = '{kind: OpNib,  nib: 4'h2, wait_us: 16'd0};
      5'd11: op = '{kind: OpNib,  nib: 4'h8, wait_us: 16'd0};
      5'd12: op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
      5'd13: op = '{kind: OpNib,  nib: 4'h0, wait_us: 16'd0};
      5'd14: op = '{kind: OpNib,  nib: 4'h8, wait_us: 16'd0};
      5'd15: op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
      5'd16: op = '{kind: OpNib,  nib: 4'h0, wait_us: 16'd0};
      5'd17: op = '{kind: OpNib,  nib: 4'h1, wait_us: 16'd0};
      5'd18: op = '{kind: OpWait, nib: 4'h0, wait_us: 16'd2000};
      5'd19: op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
      5'd20: op = '{kind: OpNib,  nib: 4'h0, wait_us: 16'd0};
      5'd21: op = '{kind: OpNib,  nib: 4'h6, wait_us: 16'd0};
      5'd22: op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
      5'd23: op = '{kind: OpNib,  nib: 4'h0, wait_us: 16'd0};
      5'd24: op = '{kind: OpNib,  nib: 4'hC, wait_us: 16'd0};
      default: op = '{kind: OpPoll, nib: 4'h0, wait_us: 16'd0};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_4bit_sequencer.sv @@
// Top level of the 4-bit character display sequencer.
//
// Usage: each request item on the slave stream (s_*) expands into a run of
// bus operations on the master stream (m_*): busy polls, nibble writes and
// waits, the final one of each run flagged by m_tlast_o. Requests are taken
// one at a time; s_tready_o is high only while no sequence is running.
// The row base register is written through cfg_* between requests; the
// poll limit index is accepted but not kept in this block.
// Timing: a taken request is first registered into the controller state,
// and the controller then loads the output register with one operation per
// cycle while m_tready_i does not stall it. A byte or plain position is 3
// operations, power-up is 25 and a position with line clear is
// 6 + 3 * LINE_CHARS (54 at sixteen characters); an unknown code emits none.
// The step counters of the controller set these counts.
// Stall: when m_tready_i is low, the output register holds its operation and
// the controller waits with it.
// Reset: the sequence stops, the output is emptied and the row base returns
// to 0x40.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_sequencer #(
  parameter int unsigned LINE_CHARS = clcd_pkg::LineCharsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request stream.
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [15:0]                  s_tdata_i,  // value[7:0], row[8], col[14:9]
  input  wire logic [2:0]                   s_tuser_i,  // req_type[2:0]
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic [clcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [clcd_pkg::CfgW-1:0]    cfg_wdata_i,
  // Operation stream.
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [23:0]                       m_tdata_o,  // nibble[3:0], wait_us[19:4]
  output logic [2:0]                        m_tuser_o,  // op_kind[1:0], reg_select[2]
  output logic                              m_tlast_o
);

  clcd_pkg::cmd_t              cmd;
  clcd_pkg::sts_t              sts;
  logic [clcd_pkg::KindW-1:0]  op_kind;
  logic                        reg_select;
  logic [clcd_pkg::NibW-1:0]   nibble;
  logic [clcd_pkg::WaitW-1:0]  wait_us;

  clcd_ctrl #(
    .LINE_CHARS (LINE_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid_i),
    .req_type_i  (s_tuser_i),
    .req_ready_o (s_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clcd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_tdata_i[7:0]),
    .row_i        (s_tdata_i[8]),
    .col_i        (s_tdata_i[14:9]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .op_kind_o    (op_kind),
    .reg_select_o (reg_select),
    .nibble_o     (nibble),
    .wait_us_o    (wait_us),
    .last_o       (m_tlast_o)
  );

  // Pack the operation fields.
  assign m_tdata_o = {4'b0000, wait_us, nibble};
  assign m_tuser_o = {reg_select, op_kind};

  // A valid request code starts a sequence and closes the request port.
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && (s_tuser_i <= clcd_pkg::ReqPosClr)) |=> !s_tready_o)
    else $error("request port stayed open after a valid request");

  // Once the final operation is loaded, the controller is idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> s_tready_o)
    else $error("controller still running after the final operation");

  // Only nibble writes carry data and register select.
  a_non_nib_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o[1:0] != clcd_pkg::OpNib)) |->
      (!m_tuser_o[2] && (m_tdata_o[3:0] == '0)))
    else $error("poll or wait operation carries nibble data");

  // Only waits carry a duration.
  a_wait_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o[1:0] != clcd_pkg::OpWait)) |-> (m_tdata_o[19:4] == '0))
    else $error("non-wait operation carries a wait time");

endmodule

`default_nettype wire

@@ rtl/clcd_ctrl.sv @@
// Controller state machine that steps through the operations of one request.
`timescale 1ns / 1ps
`default_nettype none

module clcd_ctrl #(
  parameter int unsigned LINE_CHARS = clcd_pkg::LineCharsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire logic [clcd_pkg::ReqW-1:0] req_type_i,
  output logic                           req_ready_o,
  input  wire clcd_pkg::sts_t            sts_i,
  output clcd_pkg::cmd_t                 cmd_o
);

  localparam int unsigned SpcW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [SpcW-1:0] SpcLast = SpcW'(LINE_CHARS - 1);
  localparam logic [clcd_pkg::InitIdxW-1:0] InitLast =
    clcd_pkg::InitIdxW'(clcd_pkg::InitOps - 1);

  clcd_pkg::state_e state_q, state_d;
  logic [1:0]                    phase_q, phase_d;
  logic [clcd_pkg::InitIdxW-1:0] idx_q, idx_d;
  logic [SpcW-1:0]               spc_q, spc_d;
  logic                          rs_q, rs_d;
  logic                          clr_q, clr_d;
  logic                          accept;
  logic                          adv;
  logic                          byte_end;

  assign accept   = req_valid_i && req_ready_o;
  assign adv      = sts_i.out_free && (state_q != clcd_pkg::StIdle);
  assign byte_end = (phase_q == clcd_pkg::PhLow);

  // Next state and sequence counters.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    spc_d   = spc_q;
    rs_d    = rs_q;
    clr_d   = clr_q;
    unique case (state_q)
      clcd_pkg::StIdle: begin
        phase_d = clcd_pkg::PhPoll;
        idx_d   = '0;
        spc_d   = '0;
        if (accept) begin
          case (req_type_i)
            clcd_pkg::ReqInit: state_d = clcd_pkg::StInit;
            clcd_pkg::ReqCmd: begin
              state_d = clcd_pkg::StCmd;
              rs_d    = 1'b0;
            end
            clcd_pkg::ReqChar: begin
              state_d = clcd_pkg::StCmd;
              rs_d    = 1'b1;
            end
            clcd_pkg::ReqPos: begin
              state_d = clcd_pkg::StPosA;
              clr_d   = 1'b0;
            end
            clcd_pkg::ReqPosClr: begin
              state_d = clcd_pkg::StPosA;
              clr_d   = 1'b1;
            end
            default: state_d = clcd_pkg::StIdle;
          endcase
        end
      end
      clcd_pkg::StInit: begin
        if (adv) begin
          if (idx_q == InitLast) begin
            state_d = clcd_pkg::StIdle;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      clcd_pkg::StCmd, clcd_pkg::StPosB: begin
        if (adv) begin
          if (byte_end) begin
            state_d = clcd_pkg::StIdle;
            phase_d = clcd_pkg::PhPoll;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      clcd_pkg::StPosA: begin
        if (adv) begin
          if (byte_end) begin
            state_d = clr_q ? clcd_pkg::StSpace : clcd_pkg::StIdle;
            phase_d = clcd_pkg::PhPoll;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      clcd_pkg::StSpace: begin
        if (adv) begin
          if (byte_end) begin
            phase_d = clcd_pkg::PhPoll;
            if (spc_q == SpcLast) begin
              state_d = clcd_pkg::StPosB;
            end else begin
              spc_d = spc_q + 1'b1;
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      default: state_d = clcd_pkg::StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    req_ready_o     = (state_q == clcd_pkg::StIdle);
    cmd_o.load      = accept;
    cmd_o.emit      = adv;
    cmd_o.phase     = phase_q;
    cmd_o.init_idx  = idx_q;
    cmd_o.src       = clcd_pkg::SrcInit;
    cmd_o.rs        = 1'b0;
    cmd_o.last      = 1'b0;
    unique case (state_q)
      clcd_pkg::StIdle: begin
        cmd_o.src = clcd_pkg::SrcInit;
      end
      clcd_pkg::StInit: begin
        cmd_o.src  = clcd_pkg::SrcInit;
        cmd_o.last = (idx_q == InitLast);
      end
      clcd_pkg::StCmd: begin
        cmd_o.src  = clcd_pkg::SrcVal;
        cmd_o.rs   = rs_q;
        cmd_o.last = byte_end;
      end
      clcd_pkg::StPosA: begin
        cmd_o.src  = clcd_pkg::SrcPos;
        cmd_o.last = byte_end && !clr_q;
      end
      clcd_pkg::StSpace: begin
        cmd_o.src = clcd_pkg::SrcSpace;
        cmd_o.rs  = 1'b1;
      end
      clcd_pkg::StPosB: begin
        cmd_o.src  = clcd_pkg::SrcPos;
        cmd_o.last = byte_end;
      end
      default: cmd_o.src = clcd_pkg::SrcInit;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clcd_pkg::StIdle;
      phase_q <= clcd_pkg::PhPoll;
      idx_q   <= '0;
      spc_q   <= '0;
      rs_q    <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      spc_q   <= spc_d;
      rs_q    <= rs_d;
      clr_q   <= clr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/clcd_dp.sv @@
// Datapath: request fields, row base register, operation builder and output register.
`timescale 1ns / 1ps
`default_nettype none

module clcd_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [clcd_pkg::ValW-1:0]    value_i,
  input  wire logic                         row_i,
  input  wire logic [clcd_pkg::ColW-1:0]    col_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [clcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [clcd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire clcd_pkg::cmd_t               cmd_i,
  output clcd_pkg::sts_t                    sts_o,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [clcd_pkg::KindW-1:0]        op_kind_o,
  output logic                              reg_select_o,
  output logic [clcd_pkg::NibW-1:0]         nibble_o,
  output logic [clcd_pkg::WaitW-1:0]        wait_us_o,
  output logic                              last_o
);

  logic [clcd_pkg::ValW-1:0]  val_q;
  logic                       row_q;
  logic [clcd_pkg::ColW-1:0]  col_q;
  logic [clcd_pkg::AddrW-1:0] base_q;
  logic [clcd_pkg::AddrW-1:0] addr;
  logic [clcd_pkg::ValW-1:0]  byte_val;
  clcd_pkg::init_op_t         iop;

  logic                        valid_q, valid_d;
  logic [clcd_pkg::KindW-1:0]  kind_q, kind_d;
  logic                        rs_q, rs_d;
  logic [clcd_pkg::NibW-1:0]   nib_q, nib_d;
  logic [clcd_pkg::WaitW-1:0]  wait_q, wait_d;
  logic                        last_q;

  // Request fields are held for the whole sequence.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  // Row base register. The poll limit is not kept here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= clcd_pkg::SecondRowBaseReset;
    end else if (cfg_we_i && (cfg_idx_i == clcd_pkg::CfgSecondRowBase)) begin
      base_q <= cfg_wdata_i[clcd_pkg::AddrW-1:0];
    end
  end

  // Display address wraps within the 7-bit address space.
  assign addr = clcd_pkg::AddrW'(col_q) + (row_q ? base_q : '0);
  assign iop  = clcd_pkg::init_op(cmd_i.init_idx);

  // Byte to transfer.
  always_comb begin
    case (cmd_i.src)
      clcd_pkg::SrcVal:   byte_val = val_q;
      clcd_pkg::SrcPos:   byte_val = {1'b1, addr};
      clcd_pkg::SrcSpace: byte_val = clcd_pkg::SpaceChar;
      default:            byte_val = '0;
    endcase
  end

  // Operation fields.
  always_comb begin
    kind_d = clcd_pkg::OpPoll;
    rs_d   = 1'b0;
    nib_d  = '0;
    wait_d = '0;
    if (cmd_i.src == clcd_pkg::SrcInit) begin
      kind_d = iop.kind;
      nib_d  = iop.nib;
      wait_d = iop.wait_us;
    end else begin
      case (cmd_i.phase)
        clcd_pkg::PhHigh: begin
          kind_d = clcd_pkg::OpNib;
          rs_d   = cmd_i.rs;
          nib_d  = byte_val[7:4];
        end
        clcd_pkg::PhLow: begin
          kind_d = clcd_pkg::OpNib;
          rs_d   = cmd_i.rs;
          nib_d  = byte_val[3:0];
        end
        default: kind_d = clcd_pkg::OpPoll;
      endcase
    end
  end

  // Output register: loads when empty or while its item is being taken.
  assign sts_o.out_free = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= kind_d;
      rs_q   <= rs_d;
      nib_q  <= nib_d;
      wait_q <= wait_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign op_kind_o    = kind_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
